// ===== hdl/fws_pkg.sv =====
// Shared types and codes of the formation waypoint sequencer.
`default_nettype none
package fws_pkg;

    // Item kinds carried on the input tuser
    typedef enum logic [1:0] {
        FUNC_LOAD = 2'd0,
        FUNC_POS  = 2'd1,
        FUNC_TICK = 2'd2,
        FUNC_NONE = 2'd3
    } t_func;

    // Configuration register indexes
    typedef enum logic [1:0] {
        CFG_VEHICLE_COUNT  = 2'd0,
        CFG_WAYPOINT_COUNT = 2'd1,
        CFG_TOLERANCE      = 2'd2,
        CFG_UNUSED         = 2'd3
    } t_cfg_reg;

    localparam int VCNT_W = 4;
    localparam int WCNT_W = 5;
    localparam int TOL_W  = 16;
    localparam int FVEH_W = 3;
    localparam int FWP_W  = 4;

    localparam logic [VCNT_W-1:0] VCNT_RESET = 4'd1;
    localparam logic [WCNT_W-1:0] WCNT_RESET = 5'd1;
    localparam logic [TOL_W-1:0]  TOL_RESET  = 16'd128;

    // Coordinate axis handled by the distance unit in one pass
    typedef enum logic [1:0] {
        AXIS_X = 2'd0,
        AXIS_Y = 2'd1,
        AXIS_Z = 2'd2,
        AXIS_NONE = 2'd3
    } t_axis;

    // Sequencer commands to the distance unit
    typedef struct packed {
        logic  clr;
        logic  tol_load;
        logic  diff_en;
        logic  mul_en;
        logic  acc_en;
        t_axis axis;
    } t_dist_ctl;

    // Sequencer states
    typedef enum logic [9:0] {
        ST_IDLE  = 10'b00_0000_0001,
        ST_TOL   = 10'b00_0000_0010,
        ST_CRD   = 10'b00_0000_0100,
        ST_DIFF  = 10'b00_0000_1000,
        ST_MUL   = 10'b00_0001_0000,
        ST_ACC   = 10'b00_0010_0000,
        ST_CMP   = 10'b00_0100_0000,
        ST_ERD   = 10'b00_1000_0000,
        ST_ELD   = 10'b01_0000_0000,
        ST_EWAIT = 10'b10_0000_0000
    } t_state;

endpackage
`default_nettype wire

// ===== hdl/fws_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module fws_ram #(
    parameter int WIDTH = 72,
    parameter int DEPTH = 128
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_we,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                      i_wdata,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic      [WIDTH-1:0]                      o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule
`default_nettype wire

// ===== hdl/fws_dist.sv =====
// Shared distance unit: per-axis absolute difference, one squarer, accumulator.
`default_nettype none
module fws_dist #(
    parameter int COORD_BITS = 24
) (
    input  wire logic                      i_clk,
    input  wire fws_pkg::t_dist_ctl        i_ctl,
    input  wire logic [3*COORD_BITS-1:0]   i_pos,
    input  wire logic [3*COORD_BITS-1:0]   i_tgt,
    input  wire logic [fws_pkg::TOL_W-1:0] i_tol,
    output logic                           o_arrived
);
    import fws_pkg::*;

    localparam int CB = COORD_BITS;

    logic signed [CB-1:0] w_p;
    logic signed [CB-1:0] w_t;
    logic signed [CB:0]   w_diff;
    logic        [CB:0]   w_abs;
    logic        [15:0]   w_op;
    logic        [31:0]   w_prod;

    logic [15:0] r_d;
    logic        r_over;
    logic [31:0] r_sq;
    logic [31:0] r_tol2;
    logic [33:0] r_acc;

    // Select the axis under test
    always_comb begin
        unique case (i_ctl.axis)
            AXIS_X: begin
                w_p = i_pos[0 +: CB];
                w_t = i_tgt[0 +: CB];
            end
            AXIS_Y: begin
                w_p = i_pos[CB +: CB];
                w_t = i_tgt[CB +: CB];
            end
            default: begin
                w_p = i_pos[2*CB +: CB];
                w_t = i_tgt[2*CB +: CB];
            end
        endcase
    end

    assign w_diff = (CB+1)'(w_p) - (CB+1)'(w_t);
    assign w_abs  = w_diff[CB] ? (CB+1)'(-w_diff) : (CB+1)'(w_diff);

    // One squarer shared by the tolerance and every axis
    assign w_op   = i_ctl.tol_load ? i_tol : r_d;
    assign w_prod = 32'(w_op) * 32'(w_op);

    // Difference stage; any difference of 65536 or more fails the vehicle
    always_ff @(posedge i_clk) begin
        if (i_ctl.clr) begin
            r_over <= 1'b0;
        end else if (i_ctl.diff_en) begin
            r_over <= r_over | (|w_abs[CB:16]);
        end
        if (i_ctl.diff_en) begin
            r_d <= w_abs[15:0];
        end
    end

    // Square and accumulate
    always_ff @(posedge i_clk) begin
        if (i_ctl.tol_load) begin
            r_tol2 <= w_prod;
        end
        if (i_ctl.mul_en) begin
            r_sq <= w_prod;
        end
        if (i_ctl.clr) begin
            r_acc <= '0;
        end else if (i_ctl.acc_en) begin
            r_acc <= r_acc + {2'b00, r_sq};
        end
    end

    assign o_arrived = !r_over && (r_acc < {2'b00, r_tol2});
endmodule
`default_nettype wire

// ===== hdl/formation_waypoint_sequencer_top.sv =====
// Waypoint sequencer top level: item handshake, config registers and sequencer.
//
// Steps a group of vehicles through a list of waypoints. A load item (tuser
// kind 0) writes one vehicle's target point for one waypoint slot, a position
// item (kind 1) stores a vehicle's latest position and marks it seen, and a
// tick (kind 2) advances the waypoint index when every vehicle is seen and
// strictly inside the arrival radius, then sends one command per vehicle with
// tlast on the final one, unless the advance finished the waypoint list. A
// tick checks each vehicle in turn (address, three axes of difference, square
// and accumulate, compare) through the single shared squarer and the
// registered read of the target table, then reads and sends each command,
// waiting out any output stall. The input is not ready while a tick is
// in progress. The tables have no reset and need no clearing pass; reading a
// target entry that was never loaded returns whatever the memory holds.
`default_nettype none
module formation_waypoint_sequencer_top #(
    parameter int MAX_VEHICLES  = 8,
    parameter int MAX_WAYPOINTS = 16,
    parameter int COORD_BITS    = 24
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    // tdata: vehicle[2:0], waypoint[3:0], coord_x, coord_y, coord_z, zero fill
    input  wire logic [((7+3*COORD_BITS+7)/8)*8-1:0]   i_s_tdata,
    // tuser: func[1:0]
    input  wire logic [1:0]                            i_s_tuser,
    input  wire logic                                  i_s_tvalid,
    output logic                                       o_s_tready,
    // tdata: target_vehicle[2:0], target_waypoint[3:0], target_x, target_y,
    //        target_z, zero fill
    output logic      [((7+3*COORD_BITS+7)/8)*8-1:0]   o_m_tdata,
    // tuser: advanced
    output logic                                       o_m_tuser,
    output logic                                       o_m_tlast,
    output logic                                       o_m_tvalid,
    input  wire logic                                  i_m_tready,
    input  wire logic                                  i_cfg_we,
    input  wire logic [1:0]                            i_cfg_addr,
    input  wire logic [fws_pkg::TOL_W-1:0]             i_cfg_wdata
);
    import fws_pkg::*;

    localparam int CB    = COORD_BITS;
    localparam int PW    = 3 * CB;
    localparam int DW    = ((7 + 3 * CB + 7) / 8) * 8;
    localparam int TDEP  = MAX_VEHICLES * MAX_WAYPOINTS;
    localparam int TAW   = (TDEP > 1) ? $clog2(TDEP) : 1;
    localparam int VAW   = (MAX_VEHICLES > 1) ? $clog2(MAX_VEHICLES) : 1;

    // Configuration registers
    logic [VCNT_W-1:0] r_vcount;
    logic [WCNT_W-1:0] r_wcount;
    logic [TOL_W-1:0]  r_tol;

    // Sequencer registers
    t_state            r_state, n_state;
    logic [VCNT_W-1:0] r_v, n_v;
    logic [WCNT_W-1:0] r_wi, n_wi;
    t_axis             r_axis, n_axis;
    logic              r_adv, n_adv;
    logic              r_ovalid, n_ovalid;
    logic [MAX_VEHICLES-1:0] r_seen;

    // Output payload registers
    logic [FVEH_W-1:0] r_o_veh;
    logic [FWP_W-1:0]  r_o_wp;
    logic [PW-1:0]     r_o_pt;
    logic              r_o_adv;
    logic              r_o_last;

    logic [FVEH_W-1:0] w_in_veh;
    logic [FWP_W-1:0]  w_in_wp;
    logic [PW-1:0]     w_in_pt;
    t_func             w_func;
    logic              w_acc_in;
    logic              w_veh_ok;
    logic              w_wp_ok;
    logic [VCNT_W-1:0] w_vc;
    logic [WCNT_W-1:0] w_wc;
    logic              w_last_v;
    logic              w_arrived;
    logic [PW-1:0]     w_pos_rd;
    logic [PW-1:0]     w_tgt_rd;
    logic [TAW-1:0]    w_tgt_waddr;
    logic [TAW-1:0]    w_tgt_raddr;
    t_dist_ctl         w_ctl;

    // Unpack the input item
    assign w_in_veh = i_s_tdata[2:0];
    assign w_in_wp  = i_s_tdata[6:3];
    assign w_in_pt  = i_s_tdata[7 +: PW];
    assign w_func   = t_func'(i_s_tuser);
    assign w_acc_in = i_s_tvalid && o_s_tready;
    assign w_veh_ok = 32'(w_in_veh) < MAX_VEHICLES;
    assign w_wp_ok  = 32'(w_in_wp) < MAX_WAYPOINTS;

    // Saturate the counts at the storage limits
    assign w_vc = (32'(r_vcount) > MAX_VEHICLES) ? VCNT_W'(MAX_VEHICLES) : r_vcount;
    assign w_wc = (32'(r_wcount) > MAX_WAYPOINTS) ? WCNT_W'(MAX_WAYPOINTS) : r_wcount;
    assign w_last_v = (r_v + VCNT_W'(1)) == w_vc;

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vcount <= VCNT_RESET;
            r_wcount <= WCNT_RESET;
            r_tol    <= TOL_RESET;
        end else if (i_cfg_we) begin
            unique case (t_cfg_reg'(i_cfg_addr))
                CFG_VEHICLE_COUNT:  r_vcount <= i_cfg_wdata[VCNT_W-1:0];
                CFG_WAYPOINT_COUNT: r_wcount <= i_cfg_wdata[WCNT_W-1:0];
                CFG_TOLERANCE:      r_tol    <= i_cfg_wdata;
                default:            ;
            endcase
        end
    end

    // Target table, one row of waypoints per vehicle
    assign w_tgt_waddr = TAW'(32'(w_in_veh) * MAX_WAYPOINTS + 32'(w_in_wp));
    assign w_tgt_raddr = TAW'(32'(r_v) * MAX_WAYPOINTS + 32'(r_wi));

    fws_ram #(
        .WIDTH (PW),
        .DEPTH (TDEP)
    ) u_tgt_ram (
        .i_clk   (i_clk),
        .i_we    (w_acc_in && (w_func == FUNC_LOAD) && w_veh_ok && w_wp_ok),
        .i_waddr (w_tgt_waddr),
        .i_wdata (w_in_pt),
        .i_raddr (w_tgt_raddr),
        .o_rdata (w_tgt_rd)
    );

    // Latest reported position of each vehicle
    fws_ram #(
        .WIDTH (PW),
        .DEPTH (MAX_VEHICLES)
    ) u_pos_ram (
        .i_clk   (i_clk),
        .i_we    (w_acc_in && (w_func == FUNC_POS) && w_veh_ok),
        .i_waddr (VAW'(w_in_veh)),
        .i_wdata (w_in_pt),
        .i_raddr (VAW'(r_v)),
        .o_rdata (w_pos_rd)
    );

    // Seen flags stay set until reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen <= '0;
        end else if (w_acc_in && (w_func == FUNC_POS) && w_veh_ok) begin
            r_seen[VAW'(w_in_veh)] <= 1'b1;
        end
    end

    fws_dist #(
        .COORD_BITS (COORD_BITS)
    ) u_dist (
        .i_clk     (i_clk),
        .i_ctl     (w_ctl),
        .i_pos     (w_pos_rd),
        .i_tgt     (w_tgt_rd),
        .i_tol     (r_tol),
        .o_arrived (w_arrived)
    );

    // Sequencer: arrival check vehicle by vehicle, then one command per vehicle unless the mission ended
    always_comb begin
        n_state  = r_state;
        n_v      = r_v;
        n_wi     = r_wi;
        n_axis   = r_axis;
        n_adv    = r_adv;
        n_ovalid = r_ovalid;
        w_ctl    = '{clr: 1'b0, tol_load: 1'b0, diff_en: 1'b0, mul_en: 1'b0,
                     acc_en: 1'b0, axis: r_axis};
        unique case (r_state)
            ST_IDLE: begin
                if (w_acc_in && (w_func == FUNC_TICK) && (w_vc != '0) && (r_wi < w_wc)) begin
                    n_state = ST_TOL;
                    n_v     = '0;
                    n_adv   = 1'b0;
                end
            end
            ST_TOL: begin
                w_ctl.tol_load = 1'b1;
                n_state        = ST_CRD;
            end
            ST_CRD: begin
                w_ctl.clr = 1'b1;
                if (!r_seen[VAW'(r_v)]) begin
                    n_state = ST_ERD;
                    n_v     = '0;
                end else begin
                    n_state = ST_DIFF;
                    n_axis  = AXIS_X;
                end
            end
            ST_DIFF: begin
                w_ctl.diff_en = 1'b1;
                n_state       = ST_MUL;
            end
            ST_MUL: begin
                w_ctl.mul_en = 1'b1;
                n_state      = ST_ACC;
            end
            ST_ACC: begin
                w_ctl.acc_en = 1'b1;
                if (r_axis == AXIS_Z) begin
                    n_state = ST_CMP;
                end else begin
                    n_state = ST_DIFF;
                    n_axis  = t_axis'(r_axis + 2'd1);
                end
            end
            ST_CMP: begin
                if (!w_arrived) begin
                    n_state = ST_ERD;
                    n_v     = '0;
                end else if (w_last_v) begin
                    // Every vehicle arrived: advance, stop once the mission ends
                    n_wi    = r_wi + WCNT_W'(1);
                    n_adv   = 1'b1;
                    n_v     = '0;
                    n_state = ((r_wi + WCNT_W'(1)) < w_wc) ? ST_ERD : ST_IDLE;
                end else begin
                    n_v     = r_v + VCNT_W'(1);
                    n_state = ST_CRD;
                end
            end
            ST_ERD: begin
                n_state = ST_ELD;
            end
            ST_ELD: begin
                n_ovalid = 1'b1;
                n_state  = ST_EWAIT;
            end
            ST_EWAIT: begin
                if (i_m_tready) begin
                    n_ovalid = 1'b0;
                    if (w_last_v) begin
                        n_state = ST_IDLE;
                    end else begin
                        n_v     = r_v + VCNT_W'(1);
                        n_state = ST_ERD;
                    end
                end
            end
            default: begin
                n_state  = ST_IDLE;
                n_ovalid = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_v      <= '0;
            r_wi     <= '0;
            r_axis   <= AXIS_X;
            r_adv    <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_v      <= n_v;
            r_wi     <= n_wi;
            r_axis   <= n_axis;
            r_adv    <= n_adv;
            r_ovalid <= n_ovalid;
        end
    end

    // Load the command register from the table read
    always_ff @(posedge i_clk) begin
        if (r_state == ST_ELD) begin
            r_o_veh  <= FVEH_W'(r_v);
            r_o_wp   <= FWP_W'(r_wi);
            r_o_pt   <= w_tgt_rd;
            r_o_adv  <= r_adv;
            r_o_last <= w_last_v;
        end
    end

    assign o_s_tready = (r_state == ST_IDLE);
    assign o_m_tvalid = r_ovalid;
    assign o_m_tdata  = DW'({r_o_pt, r_o_wp, r_o_veh});
    assign o_m_tuser  = r_o_adv;
    assign o_m_tlast  = r_o_last;
endmodule
`default_nettype wire
